// ===== rtl/smx_pkg.sv =====
// Shared types, opcodes and helpers for the stack machine executor.
// Depends on nothing; every other file but smx_stream_if imports it.
`default_nettype none
package smx_pkg;

  localparam int MEM_WORDS_DEF  = 32768;
  localparam int TEXT_WORDS_DEF = 32768;

  typedef enum logic [5:0] {
    OP_LEA  = 6'd0,  OP_IMM  = 6'd1,  OP_JMP  = 6'd2,  OP_CALL = 6'd3,
    OP_JZ   = 6'd4,  OP_JNZ  = 6'd5,  OP_ENT  = 6'd6,  OP_ADJ  = 6'd7,
    OP_LEV  = 6'd8,  OP_LI   = 6'd9,  OP_LC   = 6'd10, OP_SI   = 6'd11,
    OP_SC   = 6'd12, OP_PUSH = 6'd13, OP_OR   = 6'd14, OP_XOR  = 6'd15,
    OP_AND  = 6'd16, OP_EQ   = 6'd17, OP_NE   = 6'd18, OP_LT   = 6'd19,
    OP_GT   = 6'd20, OP_LE   = 6'd21, OP_GE   = 6'd22, OP_SHL  = 6'd23,
    OP_SHR  = 6'd24, OP_ADD  = 6'd25, OP_SUB  = 6'd26, OP_MUL  = 6'd27,
    OP_DIV  = 6'd28, OP_MOD  = 6'd29, OP_EXIT = 6'd37
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNSUP = 2'd1,
    ERR_DIV0  = 2'd2,
    ERR_RANGE = 2'd3
  } err_t;

  // Memory read address sources
  typedef enum logic [2:0] {
    RS_SP  = 3'd0,
    RS_ACC = 3'd1,
    RS_BP  = 3'd2,
    RS_BP1 = 3'd3,
    RS_Q   = 3'd4
  } rsel_t;

  typedef struct packed {
    logic [5:0]         opcode;
    logic signed [63:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [14:0]        next_pc;
    logic signed [63:0] acc_value;
    logic               halted;
    logic signed [63:0] exit_value;
    logic [1:0]         error_code;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic load_in;
    logic rd0;
    logic rd1;
    logic cap0;
    logic cap1;
    logic mdu_start;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic halted;
    logic need0;
    logic need1;
    logic use_mdu;
    logic mdu_done;
  } stat_t;

  function automatic logic [63:0] sext8(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/smx_stream_if.sv =====
// Valid/ready word channel used on both sides of the executor.
// Payload type is a parameter; types come from smx_pkg.
`default_nettype none
interface smx_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/smx_mdu.sv =====
// Iterative multiply / divide unit, one bit per cycle over all 64 bits.
// Signed truncating divide with remainder; low 64 bits of the product.
`default_nettype none
module smx_mdu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod,
  output logic [63:0]      quo,
  output logic [63:0]      rem
);
  import smx_pkg::*;

  localparam logic [5:0] LAST_STEP = 6'd63;

  logic        busy_r, done_r, div_r, na_r, nb_r;
  logic [5:0]  cnt_r;
  logic [63:0] x_r, y_r, p_r;
  logic [64:0] rs, diff;

  // Shift the partial remainder in one dividend bit
  assign rs   = {p_r, x_r[63]};
  assign diff = rs - {1'b0, y_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      na_r  <= a[63];
      nb_r  <= b[63];
      p_r   <= '0;
      if (is_div) begin
        x_r <= a[63] ? 64'd0 - a : a;
        y_r <= b[63] ? 64'd0 - b : b;
      end else begin
        x_r <= a;
        y_r <= b;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[64]) begin
          p_r <= diff[63:0];
          x_r <= {x_r[62:0], 1'b1};
        end else begin
          p_r <= rs[63:0];
          x_r <= {x_r[62:0], 1'b0};
        end
      end else begin
        if (y_r[0]) p_r <= p_r + x_r;
        x_r <= {x_r[62:0], 1'b0};
        y_r <= {1'b0, y_r[63:1]};
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;
  assign quo  = (na_r != nb_r) ? 64'd0 - x_r : x_r;
  assign rem  = na_r ? 64'd0 - p_r : p_r;

endmodule
`default_nettype wire

// ===== rtl/smx_dp.sv =====
// Datapath: machine registers, data/stack memory, execute logic, result word.
// Uses smx_pkg and the multiply/divide unit smx_mdu.
`default_nettype none
module smx_dp #(
  parameter int MEM_WORDS  = smx_pkg::MEM_WORDS_DEF,
  parameter int TEXT_WORDS = smx_pkg::TEXT_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smx_pkg::cmd_t     cmd,
  output smx_pkg::stat_t         stat,
  input  wire smx_pkg::in_word_t in_data,
  output smx_pkg::out_word_t     out_data
);
  import smx_pkg::*;

  localparam int          AW     = $clog2(MEM_WORDS);
  localparam int          SW     = $clog2(MEM_WORDS + 1);
  localparam int          PW     = $clog2(TEXT_WORDS);
  localparam logic [63:0] MEMW   = 64'(MEM_WORDS);
  localparam logic [63:0] TEXTW  = 64'(TEXT_WORDS);
  localparam logic [63:0] LIMIT  = 64'(MEM_WORDS) * 64'd8;
  localparam logic [SW-1:0] MEM_N  = SW'(MEM_WORDS);
  localparam logic [PW:0]   TEXT_N = (PW+1)'(TEXT_WORDS);

  // Architectural state
  logic [63:0]   acc_r, exit_r;
  logic [PW-1:0] pc_r;
  logic [SW-1:0] sp_r, bp_r;
  logic          halt_r;
  err_t          err_r;

  // Instruction and operand words
  logic [5:0]  op_r;
  logic [63:0] x_r, d0_r, d1_r, rdata_r;
  logic [AW-1:0] clr_cnt_r;

  out_word_t out_r;

  logic [63:0] mem [MEM_WORDS];

  // Decode
  logic  is_alu, need0, need1, use_mdu;
  rsel_t sel0, sel1, rsel;
  logic [AW-1:0] raddr;

  always_comb begin
    is_alu  = (op_r >= OP_OR) && (op_r <= OP_MOD);
    need0   = is_alu || op_r == OP_LI || op_r == OP_LC || op_r == OP_SI ||
              op_r == OP_SC || op_r == OP_EXIT || op_r == OP_LEV;
    need1   = (op_r == OP_LEV) || (op_r == OP_SC);
    use_mdu = (op_r == OP_MUL) || (op_r == OP_DIV) || (op_r == OP_MOD);
    if (op_r == OP_LI || op_r == OP_LC)  sel0 = RS_ACC;
    else if (op_r == OP_LEV)             sel0 = RS_BP;
    else                                 sel0 = RS_SP;
    sel1 = (op_r == OP_LEV) ? RS_BP1 : RS_Q;
    rsel = cmd.rd1 ? sel1 : sel0;
  end

  // Pick read address
  always_comb begin
    unique case (rsel)
      RS_SP:   raddr = AW'(sp_r);
      RS_ACC:  raddr = AW'(acc_r >> 3);
      RS_BP:   raddr = AW'(bp_r);
      RS_BP1:  raddr = AW'({1'b0, bp_r} + 1'b1);
      RS_Q:    raddr = AW'(rdata_r >> 3);
      default: raddr = AW'(sp_r);
    endcase
  end

  // Multiply / divide unit
  logic        mdu_done;
  logic [63:0] mdu_prod, mdu_quo, mdu_rem;

  smx_mdu u_mdu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mdu_start),
    .is_div (op_r != OP_MUL),
    .a      (rdata_r),
    .b      (acc_r),
    .done   (mdu_done),
    .prod   (mdu_prod),
    .quo    (mdu_quo),
    .rem    (mdu_rem)
  );

  // Execute
  logic [63:0]   acc_nxt, exit_nxt, l, wdata, bmask, tt, spw, s;
  logic [PW-1:0] pc_nxt, seq1, seq2;
  logic [SW-1:0] sp_nxt, bp_nxt, sp_m1;
  logic [PW:0]   p1, p2;
  logic [5:0]    lane;
  logic          halt_nxt, stop, we_ok;
  logic [AW-1:0] waddr;
  err_t          err, err_nxt;

  always_comb begin
    p1    = {1'b0, pc_r} + 1'b1;
    p2    = {1'b0, pc_r} + 2'd2;
    seq1  = (p1 >= TEXT_N) ? '0 : PW'(p1);
    seq2  = (p2 >= TEXT_N) ? PW'(p2 - TEXT_N) : PW'(p2);
    sp_m1 = sp_r - 1'b1;
    l     = d0_r;
    s     = x_r;
    tt    = 64'(sp_m1);
    spw   = 64'(sp_r);
    lane  = {d0_r[2:0], 3'b000};
    bmask = 64'hff << lane;

    acc_nxt = acc_r;
    pc_nxt  = seq1;
    sp_nxt  = sp_r;
    bp_nxt  = bp_r;
    stop    = 1'b0;
    exit_nxt = '0;
    err     = ERR_NONE;
    we_ok   = 1'b0;
    waddr   = AW'(sp_m1);
    wdata   = acc_r;

    // Pop check and divide-by-zero check ahead of the operation
    if (is_alu) begin
      if (sp_r >= MEM_N) err = ERR_RANGE;
      else if ((op_r == OP_DIV || op_r == OP_MOD) && acc_r == '0) err = ERR_DIV0;
    end

    if (err == ERR_NONE) begin
      unique case (op_r)
        OP_IMM: begin acc_nxt = x_r; pc_nxt = seq2; end
        OP_LEA: begin acc_nxt = (64'(bp_r) + x_r) << 3; pc_nxt = seq2; end
        OP_JMP: begin
          if (x_r >= TEXTW) err = ERR_RANGE; else pc_nxt = PW'(x_r);
        end
        OP_JZ, OP_JNZ: begin
          if ((acc_r == '0) == (op_r == OP_JZ)) begin
            if (x_r >= TEXTW) err = ERR_RANGE; else pc_nxt = PW'(x_r);
          end else begin
            pc_nxt = seq2;
          end
        end
        OP_CALL: begin
          if (x_r >= TEXTW || sp_r == '0) err = ERR_RANGE;
          else begin
            sp_nxt = sp_m1;
            wdata  = 64'(seq2);
            we_ok  = 1'b1;
            pc_nxt = PW'(x_r);
          end
        end
        OP_ENT: begin
          if (sp_r == '0) err = ERR_RANGE;
          else if ($signed(s) > $signed(tt) || $signed(s) < $signed(tt - MEMW))
            err = ERR_RANGE;
          else begin
            wdata  = 64'(bp_r);
            we_ok  = 1'b1;
            bp_nxt = sp_m1;
            sp_nxt = SW'(tt - s);
            pc_nxt = seq2;
          end
        end
        OP_ADJ: begin
          if ($signed(s) < $signed(64'd0 - spw) || $signed(s) > $signed(MEMW - spw))
            err = ERR_RANGE;
          else begin
            sp_nxt = SW'(spw + s);
            pc_nxt = seq2;
          end
        end
        OP_LEV: begin
          if (({1'b0, bp_r} + 1'b1) >= {1'b0, MEM_N}) err = ERR_RANGE;
          else if (d0_r > MEMW || d1_r >= TEXTW) err = ERR_RANGE;
          else begin
            sp_nxt = SW'({1'b0, bp_r} + 2'd2);
            bp_nxt = SW'(d0_r);
            pc_nxt = PW'(d1_r);
          end
        end
        OP_LI: begin
          if (acc_r >= LIMIT) err = ERR_RANGE; else acc_nxt = d0_r;
        end
        OP_LC: begin
          if (acc_r >= LIMIT) err = ERR_RANGE;
          else acc_nxt = sext8(8'(d0_r >> {acc_r[2:0], 3'b000}));
        end
        OP_SI, OP_SC: begin
          if (sp_r >= MEM_N || d0_r >= LIMIT) err = ERR_RANGE;
          else begin
            sp_nxt = sp_r + 1'b1;
            waddr  = AW'(d0_r >> 3);
            we_ok  = 1'b1;
            if (op_r == OP_SC) begin
              wdata   = (d1_r & ~bmask) | ((acc_r & 64'hff) << lane);
              acc_nxt = sext8(acc_r[7:0]);
            end
          end
        end
        OP_PUSH: begin
          if (sp_r == '0) err = ERR_RANGE;
          else begin
            sp_nxt = sp_m1;
            we_ok  = 1'b1;
          end
        end
        OP_OR:  begin acc_nxt = l | acc_r; sp_nxt = sp_r + 1'b1; end
        OP_XOR: begin acc_nxt = l ^ acc_r; sp_nxt = sp_r + 1'b1; end
        OP_AND: begin acc_nxt = l & acc_r; sp_nxt = sp_r + 1'b1; end
        OP_EQ:  begin acc_nxt = 64'(l == acc_r); sp_nxt = sp_r + 1'b1; end
        OP_NE:  begin acc_nxt = 64'(l != acc_r); sp_nxt = sp_r + 1'b1; end
        OP_LT:  begin acc_nxt = 64'($signed(l) < $signed(acc_r)); sp_nxt = sp_r + 1'b1; end
        OP_GT:  begin acc_nxt = 64'($signed(acc_r) < $signed(l)); sp_nxt = sp_r + 1'b1; end
        OP_LE:  begin acc_nxt = 64'(!($signed(acc_r) < $signed(l))); sp_nxt = sp_r + 1'b1; end
        OP_GE:  begin acc_nxt = 64'(!($signed(l) < $signed(acc_r))); sp_nxt = sp_r + 1'b1; end
        OP_SHL: begin
          acc_nxt = (|acc_r[63:6]) ? '0 : l << acc_r[5:0];
          sp_nxt  = sp_r + 1'b1;
        end
        OP_SHR: begin
          acc_nxt = (|acc_r[63:6]) ? {64{l[63]}} : 64'($signed(l) >>> acc_r[5:0]);
          sp_nxt  = sp_r + 1'b1;
        end
        OP_ADD: begin acc_nxt = l + acc_r; sp_nxt = sp_r + 1'b1; end
        OP_SUB: begin acc_nxt = l - acc_r; sp_nxt = sp_r + 1'b1; end
        OP_MUL: begin acc_nxt = mdu_prod; sp_nxt = sp_r + 1'b1; end
        OP_DIV: begin acc_nxt = mdu_quo; sp_nxt = sp_r + 1'b1; end
        OP_MOD: begin acc_nxt = mdu_rem; sp_nxt = sp_r + 1'b1; end
        OP_EXIT: begin
          if (sp_r >= MEM_N) err = ERR_RANGE;
          else begin
            exit_nxt = d0_r;
            stop     = 1'b1;
          end
        end
        default: err = ERR_UNSUP;
      endcase
    end

    // Fold the error and halt state into the committed values
    halt_nxt = halt_r;
    err_nxt  = err_r;
    if (halt_r) begin
      acc_nxt  = acc_r;
      pc_nxt   = pc_r;
      sp_nxt   = sp_r;
      bp_nxt   = bp_r;
      exit_nxt = exit_r;
      we_ok    = 1'b0;
    end else if (err != ERR_NONE) begin
      acc_nxt  = acc_r;
      pc_nxt   = pc_r;
      sp_nxt   = sp_r;
      bp_nxt   = bp_r;
      exit_nxt = '0;
      halt_nxt = 1'b1;
      err_nxt  = err;
      we_ok    = 1'b0;
    end else begin
      halt_nxt = stop;
    end
  end

  // Memory: clear sweep or committed write, one registered read
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;

  assign mem_we    = cmd.clear || (cmd.commit && we_ok);
  assign mem_waddr = cmd.clear ? clr_cnt_r : waddr;
  assign mem_wdata = cmd.clear ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd0 || cmd.rd1) rdata_r <= mem[raddr];
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // Machine registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pc_r   <= '0;
      sp_r   <= MEM_N;
      bp_r   <= MEM_N;
      halt_r <= 1'b0;
      exit_r <= '0;
      err_r  <= ERR_NONE;
    end else if (cmd.commit) begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      sp_r   <= sp_nxt;
      bp_r   <= bp_nxt;
      halt_r <= halt_nxt;
      exit_r <= exit_nxt;
      err_r  <= err_nxt;
    end
  end

  // Instruction latch, fetched words, result word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_data.opcode;
      x_r  <= in_data.operand;
    end
    if (cmd.cap0) d0_r <= rdata_r;
    if (cmd.cap1) d1_r <= rdata_r;
    if (cmd.commit) begin
      out_r.next_pc    <= 15'(pc_nxt);
      out_r.acc_value  <= acc_nxt;
      out_r.halted     <= halt_nxt;
      out_r.exit_value <= exit_nxt;
      out_r.error_code <= err_nxt;
    end
  end

  assign out_data = out_r;

  always_comb begin
    stat.clr_last = (clr_cnt_r == AW'(MEM_WORDS - 1));
    stat.halted   = halt_r;
    stat.need0    = need0;
    stat.need1    = need1;
    stat.use_mdu  = use_mdu;
    stat.mdu_done = mdu_done;
  end

endmodule
`default_nettype wire

// ===== rtl/smx_ctrl.sv =====
// Controller state machine: clear sweep, fetch of stack/memory words,
// multiply/divide wait, commit and result word handshake. Uses smx_pkg.
`default_nettype none
module smx_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire smx_pkg::stat_t stat,
  output smx_pkg::cmd_t       cmd
);
  import smx_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD0   = 7'b0000100,
    ST_CAP0  = 7'b0001000,
    ST_CAP1  = 7'b0010000,
    ST_MDU   = 7'b0100000,
    ST_EXEC  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = ST_RD0;
      end
      ST_RD0: begin
        if (!stat.halted && stat.need0) begin
          cmd.rd0   = 1'b1;
          state_nxt = ST_CAP0;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_CAP0: begin
        cmd.cap0 = 1'b1;
        if (stat.need1) begin
          cmd.rd1   = 1'b1;
          state_nxt = ST_CAP1;
        end else if (stat.use_mdu) begin
          cmd.mdu_start = 1'b1;
          state_nxt     = ST_MDU;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_CAP1: begin
        cmd.cap1  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_MDU: begin
        if (stat.mdu_done) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result word valid: set on commit, drop when taken
  always_comb begin
    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit overwrote a pending result word");

  a_mdu_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mdu_start |=> (state_r == ST_MDU))
    else $error("multiply/divide start without wait state");

  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!in_ready && !cmd.commit))
    else $error("input taken during memory clear");

endmodule
`default_nettype wire

// ===== rtl/stack_machine_executor_unit.sv =====
// Top level of the stack machine executor: controller plus datapath.
// Depends on smx_pkg, smx_stream_if, smx_ctrl, smx_dp, smx_mdu.
//
//   channel   dir  handshake      word
//   in_word   in   valid/ready    opcode, operand
//   out_word  out  valid/ready    next_pc, acc_value, halted, exit_value, error_code
//
// After reset the data memory is swept to zero, one word a cycle, through all
// MEM_WORDS words (32768 by default), during which no input word is taken.
// An instruction passes through IDLE, RD0 and EXEC, plus CAP0 with one read and
// CAP1 with two reads (LEV, SC), as the single memory port reads one word at a
// time; MUL, DIV and MOD wait in MDU for the bit-serial multiply/divide unit.
// A halted machine skips the reads and answers each word from RD0 through EXEC. A pending result word does
// not block the next input; commit waits only if the result register is full.
`default_nettype none
module stack_machine_executor_unit #(
  parameter int MEM_WORDS  = smx_pkg::MEM_WORDS_DEF,
  parameter int TEXT_WORDS = smx_pkg::TEXT_WORDS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  smx_stream_if.sink   in_word,
  smx_stream_if.source out_word
);
  import smx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smx_dp #(
    .MEM_WORDS  (MEM_WORDS),
    .TEXT_WORDS (TEXT_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_word.data),
    .out_data (out_word.data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for stack_machine_executor_unit: random and directed
// instructions, with a built-in predictor of the machine and a result scoreboard.
// Depends on smx_pkg, smx_stream_if and the executor RTL.
module tb;
  import smx_pkg::*;

  localparam int MW = MEM_WORDS_DEF;
  localparam int TW = TEXT_WORDS_DEF;
  localparam logic [63:0] BYTE_LIMIT = 64'(MW) * 8;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;

  smx_stream_if #(.T(in_word_t))  in_ch ();
  smx_stream_if #(.T(out_word_t)) out_ch ();

  stack_machine_executor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  // Predicted machine state
  logic [63:0] vm_mem [MW];
  logic [63:0] vm_acc;
  logic [14:0] vm_pc;
  int          vm_sp;
  int          vm_bp;
  bit          vm_halt;
  logic [63:0] vm_exit;
  err_t        vm_err;

  out_word_t   pending_results [$];
  int          fail_count;
  int          words_sent;
  int          results_seen;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run one instruction on the predicted machine; state changes only if commit.
  // Returns 1 when the machine is halted or the instruction would stop it.
  function automatic bit run_instr(input logic [5:0] op, input logic [63:0] x,
                                   input bit commit);
    logic [63:0] a, l, q, r, ex, mq, mr, ma, mb, wr_data;
    logic [14:0] npc, seq2;
    longint      nsp, nbp, s, t;
    int          wr_addr;
    bit          wr_en, stop;
    err_t        err;
    logic [7:0]  b;
    a = vm_acc; l = 0; ex = 0; nsp = vm_sp; nbp = vm_bp;
    npc = vm_pc + 15'd1; seq2 = vm_pc + 15'd2;
    wr_en = 0; wr_addr = 0; wr_data = 0; stop = 0; err = ERR_NONE;
    if (vm_halt) return 1;
    if (op >= OP_OR && op <= OP_MOD) begin
      if (vm_sp >= MW) err = ERR_RANGE;
      else begin
        l = vm_mem[vm_sp];
        if ((op == OP_DIV || op == OP_MOD) && a == 0) err = ERR_DIV0;
      end
    end
    if (err == ERR_NONE) begin
      case (op)
        OP_IMM: begin a = x; npc = seq2; end
        OP_LEA: begin a = (64'(vm_bp) + x) << 3; npc = seq2; end
        OP_JMP: if (x >= TW) err = ERR_RANGE; else npc = x[14:0];
        OP_JZ, OP_JNZ: begin
          if ((a == 0) == (op == OP_JZ)) begin
            if (x >= TW) err = ERR_RANGE; else npc = x[14:0];
          end else npc = seq2;
        end
        OP_CALL: begin
          if (x >= TW || vm_sp == 0) err = ERR_RANGE;
          else begin
            nsp = vm_sp - 1; wr_en = 1; wr_addr = int'(nsp); wr_data = 64'(seq2);
            npc = x[14:0];
          end
        end
        OP_ENT: begin
          s = $signed(x);
          t = longint'(vm_sp) - 1;
          if (vm_sp == 0 || s > t || s < t - MW) err = ERR_RANGE;
          else begin
            wr_en = 1; wr_addr = int'(t); wr_data = 64'(vm_bp);
            nbp = t; nsp = t - s; npc = seq2;
          end
        end
        OP_ADJ: begin
          s = $signed(x);
          if (s < -longint'(vm_sp) || s > longint'(MW) - vm_sp) err = ERR_RANGE;
          else begin nsp = vm_sp + s; npc = seq2; end
        end
        OP_LEV: begin
          if (vm_bp + 1 >= MW) err = ERR_RANGE;
          else begin
            q = vm_mem[vm_bp]; r = vm_mem[vm_bp + 1];
            if (q > MW || r >= TW) err = ERR_RANGE;
            else begin nsp = vm_bp + 2; nbp = longint'(q); npc = r[14:0]; end
          end
        end
        OP_LI: if (a >= BYTE_LIMIT) err = ERR_RANGE; else a = vm_mem[a >> 3];
        OP_LC: begin
          if (a >= BYTE_LIMIT) err = ERR_RANGE;
          else begin
            b = 8'(vm_mem[a >> 3] >> (a[2:0] * 8));
            a = {{56{b[7]}}, b};
          end
        end
        OP_SI, OP_SC: begin
          if (vm_sp >= MW) err = ERR_RANGE;
          else begin
            q = vm_mem[vm_sp];
            if (q >= BYTE_LIMIT) err = ERR_RANGE;
            else begin
              nsp = vm_sp + 1; wr_en = 1; wr_addr = int'(q >> 3);
              if (op == OP_SI) wr_data = a;
              else begin
                r = 64'(q[2:0]) * 8;
                wr_data = (vm_mem[wr_addr] & ~(64'hff << r)) | ((a & 64'hff) << r);
                a = {{56{a[7]}}, a[7:0]};
              end
            end
          end
        end
        OP_PUSH: begin
          if (vm_sp == 0) err = ERR_RANGE;
          else begin nsp = vm_sp - 1; wr_en = 1; wr_addr = int'(nsp); wr_data = a; end
        end
        OP_OR:  begin a = l | a; nsp++; end
        OP_XOR: begin a = l ^ a; nsp++; end
        OP_AND: begin a = l & a; nsp++; end
        OP_EQ:  begin a = 64'(l == a); nsp++; end
        OP_NE:  begin a = 64'(l != a); nsp++; end
        OP_LT:  begin a = 64'($signed(l) < $signed(a)); nsp++; end
        OP_GT:  begin a = 64'($signed(a) < $signed(l)); nsp++; end
        OP_LE:  begin a = 64'(!($signed(a) < $signed(l))); nsp++; end
        OP_GE:  begin a = 64'(!($signed(l) < $signed(a))); nsp++; end
        OP_SHL: begin a = (a >= 64) ? 64'd0 : (l << a[5:0]); nsp++; end
        OP_SHR: begin a = (a >= 64) ? {64{l[63]}} : 64'($signed(l) >>> a[5:0]); nsp++; end
        OP_ADD: begin a = l + a; nsp++; end
        OP_SUB: begin a = l - a; nsp++; end
        OP_MUL: begin a = l * a; nsp++; end
        OP_DIV, OP_MOD: begin
          // truncating divide on magnitudes, signs fixed up afterwards
          ma = l[63] ? -l : l;
          mb = a[63] ? -a : a;
          mq = ma / mb; mr = ma % mb;
          if (op == OP_DIV) a = (l[63] != a[63]) ? -mq : mq;
          else a = l[63] ? -mr : mr;
          nsp++;
        end
        OP_EXIT: begin
          if (vm_sp >= MW) err = ERR_RANGE;
          else begin ex = vm_mem[vm_sp]; stop = 1; end
        end
        default: err = ERR_UNSUP;
      endcase
    end
    if (commit) begin
      vm_halt = 1;
      if (err != ERR_NONE) begin
        vm_err = err; vm_exit = 0;
      end else begin
        vm_acc = a; vm_pc = npc; vm_sp = int'(nsp); vm_bp = int'(nbp);
        vm_halt = stop; vm_exit = ex;
        if (wr_en) vm_mem[wr_addr] = wr_data;
      end
    end
    return (err != ERR_NONE) || stop;
  endfunction

  function automatic out_word_t machine_view();
    out_word_t w;
    w.next_pc    = vm_pc;
    w.acc_value  = vm_acc;
    w.halted     = vm_halt;
    w.exit_value = vm_halt ? vm_exit : 64'd0;
    w.error_code = vm_halt ? vm_err : ERR_NONE;
    return w;
  endfunction

  // Drive one word, hold until accepted, then record the predicted result
  task automatic send_word(input logic [5:0] op, input logic [63:0] x);
    in_ch.valid     <= 1'b1;
    in_ch.data      <= '{opcode: op, operand: x};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(run_instr(op, x, 1'b1));
    pending_results.push_back(machine_view());
    words_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Send only if the machine keeps running
  task automatic send_safe(input logic [5:0] op, input logic [63:0] x);
    if (!run_instr(op, x, 1'b0)) send_word(op, x);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_safe(OP_IMM, 64'h7fff_ffff_ffff_ffff);
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, 64'h8000_0000_0000_0000);
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, -64'sd1);
    send_safe(OP_DIV, 0);          // most negative over -1 wraps
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, -64'sd1);
    send_safe(OP_MOD, 0);
    send_safe(OP_IMM, 64'd64);
    send_safe(OP_SHR, 0);          // shift of 64 or more
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, 64'd70);
    send_safe(OP_SHL, 0);
    send_safe(OP_IMM, 64'd800);
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, 64'h0123_4567_89ab_cdef);
    send_safe(OP_SI, 0);
    send_safe(OP_IMM, 64'd805);
    send_safe(OP_PUSH, 0);
    send_safe(OP_IMM, 64'hff);
    send_safe(OP_SC, 0);           // byte store, sign extended
    send_safe(OP_IMM, 64'd807);
    send_safe(OP_LC, 0);
    send_safe(OP_CALL, 64'd300);
    send_safe(OP_ENT, 64'd2);
    send_safe(OP_LEA, -64'sd1);
    send_safe(OP_LI, 0);
    send_safe(OP_LEV, 0);
    send_safe(OP_JZ, 64'd5);
    send_safe(OP_JNZ, 64'd32767);
    send_safe(OP_ADJ, 64'd1);
  endtask

  // Pick a mostly well-formed instruction for the present machine state
  task automatic pick_word(output logic [5:0] op, output logic [63:0] x);
    int k;
    k = $urandom_range(0, 99);
    x = {$urandom, $urandom};
    if (k < 16) begin
      op = OP_IMM;
      case ($urandom_range(0, 2))
        0: ;
        1: x = 64'($urandom_range(0, 70));
        default: x = 64'(vm_sp + $urandom_range(0, 8)) * 8 + $urandom_range(0, 7);
      endcase
    end else if (k < 28) op = OP_PUSH;
    else if (k < 52) op = 6'($urandom_range(OP_OR, OP_MOD));
    else if (k < 60) op = ($urandom_range(0, 1)) ? OP_LI : OP_LC;
    else if (k < 68) op = ($urandom_range(0, 1)) ? OP_SI : OP_SC;
    else if (k < 72) begin
      op = OP_LEA; x = 64'($signed($urandom_range(0, 8)) - 4);
    end else if (k < 80) begin
      op = 6'($urandom_range(OP_JMP, OP_JNZ));
      if ($urandom_range(0, 9) != 0) x = 64'($urandom_range(0, TW - 1));
    end else if (k < 84) begin
      op = OP_CALL; x = 64'($urandom_range(0, TW - 1));
    end else if (k < 89) begin
      op = OP_ENT; x = 64'($urandom_range(0, 4));
    end else if (k < 94) begin
      op = OP_ADJ; x = 64'($signed($urandom_range(0, 6)) - 2);
    end else op = OP_LEV;
  endtask

  task automatic test_random(input int count);
    logic [5:0]  op;
    logic [63:0] x;
    int          tries;
    repeat (count) begin
      tries = 0;
      do begin
        pick_word(op, x);
        tries++;
      end while (run_instr(op, x, 1'b0) && tries < 40);
      if (run_instr(op, x, 1'b0)) begin
        op = OP_IMM; x = {$urandom, $urandom};
      end
      send_word(op, x);
    end
  endtask

  // Stop the machine one way, then show that later words are ignored
  task automatic test_halt();
    case ($urandom_range(0, 4))
      0: begin send_word(OP_PUSH, 0); send_word(OP_EXIT, 0); end
      1: send_word(6'($urandom_range(30, 36)), 0);
      2: send_word(6'($urandom_range(38, 63)), {$urandom, $urandom});
      3: begin send_word(OP_PUSH, 0); send_word(OP_IMM, 0); send_word(OP_DIV, 0); end
      default: send_word(OP_JMP, 64'hffff_ffff_ffff_0000);
    endcase
    repeat (4) send_word(6'($urandom_range(0, 63)), {$urandom, $urandom});
  endtask

  // Compare one field of a result
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Score each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result word, actual %p", $time, out_ch.data);
      end else begin
        check_field("next_pc", 64'(pending_results[0].next_pc), 64'(out_ch.data.next_pc));
        check_field("acc_value", pending_results[0].acc_value, out_ch.data.acc_value);
        check_field("halted", 64'(pending_results[0].halted), 64'(out_ch.data.halted));
        check_field("exit_value", pending_results[0].exit_value, out_ch.data.exit_value);
        check_field("error_code", 64'(pending_results[0].error_code),
                    64'(out_ch.data.error_code));
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stack_machine_executor_unit: mismatch");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    cycle_count  = 0;
    fail_count   = 0;
    words_sent   = 0;
    results_seen = 0;
    for (int i = 0; i < MW; i++) vm_mem[i] = 0;
    vm_acc = 0; vm_pc = 0; vm_sp = MW; vm_bp = MW;
    vm_halt = 0; vm_exit = 0; vm_err = ERR_NONE;
    tx_idle_pct = 7; rx_idle_pct = 75;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(400);
    wait_drained();
    tx_idle_pct = 75; rx_idle_pct = 7;
    test_random(400);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random(400);
    test_halt();
    wait_drained();
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t %0d predicted results never arrived", $time, pending_results.size());
    end

    $display("ran %0d instruction words (directed, random, halt) and scored %0d results",
             words_sent, results_seen);
    if (fail_count == 0) begin
      $display("stack_machine_executor_unit: match");
    end else begin
      $display("stack_machine_executor_unit: mismatch");
    end
    $finish;
  end
endmodule
